[hw/rtl/lbd_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lbd_pkg
// shared sizes, request and status codes and the sequencer state type of the
// buffer directory
// ----------------------------------------------------------------------------
package lbd_pkg;

	localparam int SLOT_COUNT       = 32;
	localparam int DISK_BLOCK_COUNT = 8192;
	localparam int AGE_BITS         = 16;

	localparam int SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W  = $clog2(SLOT_COUNT + 1);
	localparam int BLK_W  = (DISK_BLOCK_COUNT > 1) ? $clog2(DISK_BLOCK_COUNT) : 1;

	// port widths fixed by the transaction format
	localparam int KIND_W   = 2;
	localparam int BNUM_W   = 16;
	localparam int STATUS_W = 2;
	localparam int SLOTO_W  = 5;
	localparam int WBBLK_W  = 13;

	typedef enum logic [KIND_W-1:0] {
		KIND_ALLOC  = 2'd0,
		KIND_LOOKUP = 2'd1,
		KIND_DIRTY  = 2'd2,
		KIND_UNUSED = 2'd3
	} kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STATUS_OK           = 2'd0,
		STATUS_OUT_OF_BOUND = 2'd1,
		STATUS_NOT_IN_BUF   = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

endpackage

`default_nettype wire

[hw/rtl/lru_buffer_directory.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_buffer_directory
// slot directory of a fully associative buffer pool with oldest-first
// replacement, scanned one slot per cycle by a small sequencer
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. An allocate,
// look-up or set-dirty transaction keeps the block busy while it streams the
// age and block memories slot by slot through the shared age/compare unit,
// lets the registered memory read drain and then commits the chosen slot.
// The result appears with done high in the cycle after the commit, when busy
// is already low again. A transaction whose block number is at or above the
// disk size, or whose kind is unused, is answered without a scan: done is
// high in the cycle after it was taken and busy never rises. The result is
// on the outputs for exactly one cycle and cannot be held off, so the
// receiver must capture it whenever done is high.
// ----------------------------------------------------------------------------
module lru_buffer_directory (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          start,
	output logic                               busy,
	input  wire logic [lbd_pkg::KIND_W-1:0]    kind,
	input  wire logic [lbd_pkg::BNUM_W-1:0]    block_number,
	output logic                               done,
	output logic [lbd_pkg::STATUS_W-1:0]       status,
	output logic [lbd_pkg::SLOTO_W-1:0]        slot_index,
	output logic                               writeback_needed,
	output logic [lbd_pkg::WBBLK_W-1:0]        writeback_block
);
	import lbd_pkg::*;

	// sequencer
	state_t state_q, state_d;
	logic [CNT_W-1:0] cnt_q;          // slot whose memories are read this cycle
	logic             scan_last;      // every slot has been read

	// request held for the whole scan
	logic [KIND_W-1:0] kind_q;
	logic [BLK_W-1:0]  target_q;

	// per-slot flags, cleared by reset
	logic [SLOT_COUNT-1:0] occ_q;
	logic [SLOT_COUNT-1:0] dirty_q;

	// age and block memories, no reset: a free slot's entry is never used
	logic [AGE_BITS-1:0] age_mem [SLOT_COUNT];
	logic [BLK_W-1:0]    blk_mem [SLOT_COUNT];

	// stage 1: registered memory read data for one slot
	logic                valid_s1;
	logic [SLOT_W-1:0]   idx_s1;
	logic [AGE_BITS-1:0] age_s1;
	logic [BLK_W-1:0]    blk_s1;

	// scan results
	logic                free_found_q;
	logic [SLOT_W-1:0]   free_idx_q;
	logic                hit_found_q;
	logic [SLOT_W-1:0]   hit_idx_q;
	logic [SLOT_W-1:0]   best_idx_q;
	logic [AGE_BITS-1:0] best_age_q;
	logic [BLK_W-1:0]    best_blk_q;

	// shared age / compare unit
	logic                occ_s1;
	logic [AGE_BITS-1:0] age_next;
	logic                is_alloc;
	logic [SLOT_W-1:0]   pick;

	// age memory write port
	logic                age_we;
	logic [SLOT_W-1:0]   age_waddr;
	logic [AGE_BITS-1:0] age_wdata;

	// request screening
	logic accept;
	logic out_of_bound;
	logic reject;

	assign accept       = start && !busy;
	assign out_of_bound = {1'b0, block_number} >= (BNUM_W + 1)'(DISK_BLOCK_COUNT);
	assign reject       = (kind == KIND_UNUSED) || out_of_bound;
	assign busy         = (state_q != ST_IDLE);
	assign scan_last    = (cnt_q == CNT_W'(SLOT_COUNT));

	assign is_alloc = (kind_q == KIND_ALLOC);
	assign occ_s1   = occ_q[idx_s1];
	// saturating age step, only for occupied slots
	assign age_next = (occ_s1 && (age_s1 != '1)) ? age_s1 + AGE_BITS'(1) : age_s1;
	// lowest free slot wins, else the oldest one
	assign pick     = free_found_q ? free_idx_q : best_idx_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && !reject)
					state_d = ST_SCAN;
			end
			ST_SCAN: begin
				if (scan_last)
					state_d = ST_FINISH;
			end
			ST_FINISH: state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// age write: aging during an allocate scan, clearing on commit of an allocate
	always_comb begin
		age_we    = 1'b0;
		age_waddr = idx_s1;
		age_wdata = age_next;
		if (state_q == ST_FINISH) begin
			age_we    = is_alloc;
			age_waddr = pick;
			age_wdata = '0;
		end else if (valid_s1) begin
			age_we    = is_alloc && occ_s1;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= '0;
			valid_s1     <= 1'b0;
			occ_q        <= '0;
			dirty_q      <= '0;
			free_found_q <= 1'b0;
			hit_found_q  <= 1'b0;
			done         <= 1'b0;
		end else begin
			state_q  <= state_d;
			valid_s1 <= (state_q == ST_SCAN) && !scan_last;
			done     <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					cnt_q        <= '0;
					free_found_q <= 1'b0;
					hit_found_q  <= 1'b0;
					if (accept && reject)
						done <= 1'b1;
				end
				ST_SCAN: begin
					if (!scan_last)
						cnt_q <= cnt_q + CNT_W'(1);
					if (valid_s1) begin
						if (!occ_s1)
							free_found_q <= 1'b1;
						if (occ_s1 && (blk_s1 == target_q))
							hit_found_q <= 1'b1;
					end
				end
				ST_FINISH: begin
					done <= 1'b1;
					if (is_alloc) begin
						occ_q[pick]   <= 1'b1;
						dirty_q[pick] <= 1'b0;
					end else if (kind_q == KIND_DIRTY && hit_found_q) begin
						dirty_q[hit_idx_q] <= 1'b1;
					end
				end
				default: ;
			endcase
		end
	end

	// request capture, scan bookkeeping and result registers
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q   <= kind;
			target_q <= block_number[BLK_W-1:0];
		end
		if (state_q == ST_IDLE && accept && reject) begin
			status           <= (kind == KIND_UNUSED) ? STATUS_NOT_IN_BUF
			                                          : STATUS_OUT_OF_BOUND;
			slot_index       <= '0;
			writeback_needed <= 1'b0;
			writeback_block  <= '0;
		end
		if (valid_s1) begin
			if (!occ_s1 && !free_found_q)
				free_idx_q <= idx_s1;
			if (occ_s1 && (blk_s1 == target_q) && !hit_found_q)
				hit_idx_q <= idx_s1;
			// strict compare keeps the lowest index among equal ages
			if ((idx_s1 == '0) || (age_next > best_age_q)) begin
				best_idx_q <= idx_s1;
				best_age_q <= age_next;
				best_blk_q <= blk_s1;
			end
		end
		if (state_q == ST_FINISH) begin
			writeback_needed <= 1'b0;
			writeback_block  <= '0;
			if (is_alloc) begin
				status     <= STATUS_OK;
				slot_index <= SLOTO_W'(pick);
				if (!free_found_q && dirty_q[best_idx_q]) begin
					writeback_needed <= 1'b1;
					writeback_block  <= WBBLK_W'(best_blk_q);
				end
			end else if (hit_found_q) begin
				status     <= STATUS_OK;
				slot_index <= (kind_q == KIND_LOOKUP) ? SLOTO_W'(hit_idx_q) : '0;
			end else begin
				status     <= STATUS_NOT_IN_BUF;
				slot_index <= '0;
			end
		end
	end

	// memories: one read and one write port each, registered read
	always_ff @(posedge clk) begin
		if (age_we)
			age_mem[age_waddr] <= age_wdata;
		if (state_q == ST_FINISH && is_alloc)
			blk_mem[pick] <= target_q;
		if (state_q == ST_SCAN && !scan_last) begin
			age_s1 <= age_mem[cnt_q[SLOT_W-1:0]];
			blk_s1 <= blk_mem[cnt_q[SLOT_W-1:0]];
			idx_s1 <= cnt_q[SLOT_W-1:0];
		end
	end

	// checks
	a_done_source: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == ST_FINISH) || $past(accept && reject))
		else $error("result without a finished transaction");

	a_finish_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINISH) |=> !busy && done)
		else $error("commit did not end the transaction");

	a_wb_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(done && writeback_needed) |-> (status == STATUS_OK) && (kind_q == KIND_ALLOC))
		else $error("write-back on a non-allocate result");

	a_fail_slot0: assert property (@(posedge clk) disable iff (!arst_n)
		(done && (status != STATUS_OK)) |-> (slot_index == '0) && !writeback_needed)
		else $error("failed transaction carries a slot");

endmodule

`default_nettype wire

[tb/lru_buffer_directory_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_buffer_directory_tb
// self-checking bench for the buffer pool slot directory: a tracker keeps its
// own copy of slot occupancy, dirty bits, held blocks and ages, predicts the
// answer of every accepted transaction and compares it with the done strobe
// ----------------------------------------------------------------------------
module lru_buffer_directory_tb;

	import lbd_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 2 * SLOT_COUNT + 8;
	localparam int PHASE_ITEMS = 284;
	localparam int RECENT_DEPTH = 48;

	// one answer of the directory, in port order
	typedef struct packed {
		status_t              status;
		logic [SLOTO_W-1:0]   slot;
		logic                 wb_need;
		logic [WBBLK_W-1:0]   wb_block;
	} answer_t;

	// ------------------------------------------------------------------------
	// tracker: mirrors the directory state and checks answers in order
	// ------------------------------------------------------------------------
	class slot_map_tracker;
		logic                 occupied[SLOT_COUNT];
		logic                 dirty[SLOT_COUNT];
		logic [WBBLK_W-1:0]   held_block[SLOT_COUNT];
		logic [AGE_BITS-1:0]  age[SLOT_COUNT];
		answer_t              awaited_answers[$];
		int                   mismatch_count;

		function new();
			for (int i = 0; i < SLOT_COUNT; i++) begin
				occupied[i] = 1'b0;
				dirty[i] = 1'b0;
				held_block[i] = '0;
				age[i] = '0;
			end
			mismatch_count = 0;
		endfunction

		// works out the answer and applies the state change of one transaction
		function answer_t resolve_request(logic [KIND_W-1:0] k, logic [BNUM_W-1:0] bn);
			answer_t a;
			int pick;
			a = '0;
			a.status = STATUS_OK;
			pick = -1;
			if (k == KIND_UNUSED) begin
				a.status = STATUS_NOT_IN_BUF;
			end else if (bn >= DISK_BLOCK_COUNT) begin
				a.status = STATUS_OUT_OF_BOUND;
			end else if (k == KIND_ALLOC) begin
				// age occupied slots first, saturating
				for (int i = 0; i < SLOT_COUNT; i++)
					if (occupied[i] && age[i] != {AGE_BITS{1'b1}})
						age[i] = age[i] + 1'b1;
				for (int i = 0; i < SLOT_COUNT; i++)
					if (pick < 0 && !occupied[i])
						pick = i;
				if (pick < 0) begin
					// pool full: oldest slot, lowest index on ties
					pick = 0;
					for (int i = 1; i < SLOT_COUNT; i++)
						if (age[i] > age[pick])
							pick = i;
					if (dirty[pick]) begin
						a.wb_need = 1'b1;
						a.wb_block = held_block[pick];
					end
				end
				occupied[pick] = 1'b1;
				dirty[pick] = 1'b0;
				held_block[pick] = bn[WBBLK_W-1:0];
				age[pick] = '0;
				a.slot = SLOTO_W'(pick);
			end else begin
				for (int i = 0; i < SLOT_COUNT; i++)
					if (pick < 0 && occupied[i] && {3'b000, held_block[i]} == bn)
						pick = i;
				if (pick < 0)
					a.status = STATUS_NOT_IN_BUF;
				else if (k == KIND_DIRTY)
					dirty[pick] = 1'b1;
				else
					a.slot = SLOTO_W'(pick);
			end
			return a;
		endfunction

		function void note_request(logic [KIND_W-1:0] k, logic [BNUM_W-1:0] bn);
			awaited_answers.push_back(resolve_request(k, bn));
		endfunction

		function void check_answer(logic [STATUS_W-1:0] st, logic [SLOTO_W-1:0] sl,
				logic wn, logic [WBBLK_W-1:0] wb);
			answer_t e;
			if (awaited_answers.size() == 0) begin
				$error("answer with no transaction pending: status %0d slot %0d", st, sl);
				mismatch_count++;
				return;
			end
			e = awaited_answers.pop_front();
			if (st !== e.status) begin
				$error("status: expected %0d, got %0d", e.status, st);
				mismatch_count++;
			end
			if (sl !== e.slot) begin
				$error("slot_index: expected %0d, got %0d", e.slot, sl);
				mismatch_count++;
			end
			if (wn !== e.wb_need) begin
				$error("writeback_needed: expected %0d, got %0d", e.wb_need, wn);
				mismatch_count++;
			end
			if (wb !== e.wb_block) begin
				$error("writeback_block: expected %0d, got %0d", e.wb_block, wb);
				mismatch_count++;
			end
		endfunction

		function int pending();
			return awaited_answers.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// clock, reset and the block
	// ------------------------------------------------------------------------
	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic [KIND_W-1:0]    kind = KIND_ALLOC;
	logic [BNUM_W-1:0]    block_number = '0;
	logic                 busy;
	logic                 done;
	logic [STATUS_W-1:0]  status;
	logic [SLOTO_W-1:0]   slot_index;
	logic                 writeback_needed;
	logic [WBBLK_W-1:0]   writeback_block;

	slot_map_tracker      pool_tracker = new();
	logic [BNUM_W-1:0]    recent_blocks[$];
	int                   cycle_count = 0;

	always #1 clk = ~clk;

	lru_buffer_directory dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.start            (start),
		.busy             (busy),
		.kind             (kind),
		.block_number     (block_number),
		.done             (done),
		.status           (status),
		.slot_index       (slot_index),
		.writeback_needed (writeback_needed),
		.writeback_block  (writeback_block)
	);

	// ------------------------------------------------------------------------
	// monitor: all values read here are the ones held before the edge
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (done)
			pool_tracker.check_answer(status, slot_index, writeback_needed, writeback_block);
		// a transaction is taken on start high with busy low
		if (arst_n && start && !busy)
			pool_tracker.note_request(kind, block_number);
	end

	// ------------------------------------------------------------------------
	// driver tasks, all called right after a rising edge
	// ------------------------------------------------------------------------

	// holds start high until the block takes the transaction
	task automatic issue_request(logic [KIND_W-1:0] k, logic [BNUM_W-1:0] bn);
		start <= 1'b1;
		kind <= k;
		block_number <= bn;
		if (k == KIND_ALLOC && bn < DISK_BLOCK_COUNT) begin
			recent_blocks.push_back(bn);
			if (recent_blocks.size() > RECENT_DEPTH)
				void'(recent_blocks.pop_front());
		end
		do
			@(posedge clk);
		while (busy);
	endtask

	// idles the sender with the given chance per cycle; junk on the fields
	// while start is low must be ignored
	task automatic hold_off(int pct);
		while ($urandom_range(99) < pct) begin
			start <= 1'b0;
			kind <= KIND_W'($urandom);
			block_number <= BNUM_W'($urandom);
			@(posedge clk);
		end
	endtask

	// sender pauses until every awaited answer is back; the first edge lets
	// the monitor note a transaction taken at the edge just passed
	task automatic drain_answers();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pool_tracker.pending() != 0);
	endtask

	// a block number that is probably held right now
	function automatic logic [BNUM_W-1:0] likely_held();
		if (recent_blocks.size() != 0 && $urandom_range(9) < 8)
			return recent_blocks[$urandom_range(recent_blocks.size() - 1)];
		return BNUM_W'($urandom_range(DISK_BLOCK_COUNT - 1));
	endfunction

	// mostly well-formed traffic on a small working set, some noise
	task automatic random_request();
		int r;
		int q;
		logic [BNUM_W-1:0] bn;
		r = $urandom_range(99);
		if (r < 3) begin
			issue_request(KIND_UNUSED, BNUM_W'($urandom));
		end else if (r < 9) begin
			issue_request(KIND_W'($urandom_range(2)),
				BNUM_W'($urandom_range(65535, DISK_BLOCK_COUNT)));
		end else if (r < 45) begin
			q = $urandom_range(9);
			if (q < 5)
				bn = BNUM_W'($urandom_range(DISK_BLOCK_COUNT - 1));
			else if (q < 7)
				bn = likely_held();
			else
				bn = BNUM_W'($urandom_range(47));
			issue_request(KIND_ALLOC, bn);
		end else if (r < 72) begin
			issue_request(KIND_LOOKUP, likely_held());
		end else begin
			issue_request(KIND_DIRTY, likely_held());
		end
	endtask

	// ------------------------------------------------------------------------
	// watchdog
	// ------------------------------------------------------------------------
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("end of test: mismatches");
		$finish;
	end

	// ------------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------------
	initial begin
		int idle_pct[3];
		idle_pct[0] = 13;
		idle_pct[1] = 54;
		idle_pct[2] = 0;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty pool: misses, then the unused kind at both field extremes
		issue_request(KIND_LOOKUP, 16'd0);
		issue_request(KIND_DIRTY, 16'd0);
		issue_request(KIND_UNUSED, 16'd0);
		issue_request(KIND_UNUSED, 16'hFFFF);
		// first allocations, largest valid block, then out-of-bound for allocate, look-up and set-dirty
		issue_request(KIND_ALLOC, 16'd0);
		issue_request(KIND_ALLOC, BNUM_W'(DISK_BLOCK_COUNT - 1));
		issue_request(KIND_ALLOC, BNUM_W'(DISK_BLOCK_COUNT));
		issue_request(KIND_LOOKUP, 16'hFFFF);
		issue_request(KIND_DIRTY, 16'hE000);
		// hits, marking dirty, and a second copy of a held block
		issue_request(KIND_LOOKUP, BNUM_W'(DISK_BLOCK_COUNT - 1));
		issue_request(KIND_DIRTY, BNUM_W'(DISK_BLOCK_COUNT - 1));
		issue_request(KIND_ALLOC, 16'd0);
		issue_request(KIND_LOOKUP, 16'd0);
		issue_request(KIND_DIRTY, 16'd0);
		issue_request(KIND_LOOKUP, 16'd1);
		issue_request(KIND_ALLOC, 16'h1555);
		issue_request(KIND_ALLOC, 16'h0AAA);
		issue_request(KIND_DIRTY, 16'h1555);
		issue_request(KIND_LOOKUP, 16'h0AAA);
		drain_answers();

		// random traffic: light idling, heavy idling, then back to back;
		// ages never exceed the pool size, so saturation cannot be reached
		for (int phase = 0; phase < 3; phase++) begin
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				hold_off(idle_pct[phase]);
				random_request();
				if ($urandom_range(99) == 0)
					drain_answers();
			end
			drain_answers();
		end

		repeat (TAIL_CYCLES) @(posedge clk);
		if (pool_tracker.mismatch_count == 0 && pool_tracker.pending() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule
